>>> rtl/core/mhps_pkg.sv
`timescale 1ns / 1ps
// Package for the marker hold phase switch: field widths, constants and the
// structs passed among the top level, the config block and the decision core. No dependencies.
package mhps_pkg;

  localparam int unsigned IdW     = 10;
  localparam int unsigned PixW    = 12;
  localparam int unsigned FracW   = 17;
  localparam int unsigned FracSh  = 16;
  localparam int unsigned CountW  = 20;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThrW    = FracW + PixW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CountW-1:0] RunLimit = CountW'(1000000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_TERMINAL_MARKER = 3'd0,
    REG_MIN_WIDTH       = 3'd1,
    REG_MIN_HEIGHT      = 3'd2,
    REG_MIN_FRACTION    = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5,
    REG_MIN_FRAMES      = 3'd6,
    REG_HOLD_TIME       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [IdW-1:0]    terminal_marker;
    logic [PixW-1:0]   min_width;
    logic [PixW-1:0]   min_height;
    logic [CountW-1:0] min_frames;
    logic [HoldW-1:0]  hold_time;
    logic              frac_en;
    logic [ThrW-1:0]   thr_w;
    logic [ThrW-1:0]   thr_h;
  } cfg_t;

  typedef struct packed {
    logic [IdW-1:0]   marker_id;
    logic [PixW-1:0]  box_width;
    logic [PixW-1:0]  box_height;
    logic [TimeW-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] big_count;
    logic              switched;
    logic              phase;
  } res_t;

endpackage

>>> rtl/core/mhps_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and registered fraction thresholds.
// Depends on mhps_pkg.
module mhps_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mhps_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mhps_pkg::CfgDataW-1:0]    cfg_data_i,
  output mhps_pkg::cfg_t                   cfg_o
);
  import mhps_pkg::*;

  logic [IdW-1:0]    terminal_marker_q;
  logic [PixW-1:0]   min_width_q;
  logic [PixW-1:0]   min_height_q;
  logic [FracW-1:0]  min_fraction_q;
  logic [PixW-1:0]   image_width_q;
  logic [PixW-1:0]   image_height_q;
  logic [CountW-1:0] min_frames_q;
  logic [HoldW-1:0]  hold_time_q;
  logic [ThrW-1:0]   thr_w_q, thr_w_d;
  logic [ThrW-1:0]   thr_h_q, thr_h_d;
  logic              frac_en_q, frac_en_d;

  always_comb begin
    thr_w_d   = ThrW'(min_fraction_q) * ThrW'(image_width_q);
    thr_h_d   = ThrW'(min_fraction_q) * ThrW'(image_height_q);
    frac_en_d = (min_fraction_q != '0) && (image_width_q != '0) && (image_height_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      terminal_marker_q <= '0;
      min_width_q       <= '0;
      min_height_q      <= '0;
      min_fraction_q    <= '0;
      image_width_q     <= '0;
      image_height_q    <= '0;
      min_frames_q      <= '0;
      hold_time_q       <= '0;
      thr_w_q           <= '0;
      thr_h_q           <= '0;
      frac_en_q         <= 1'b0;
    end else begin
      // thresholds are registered; user changes config only when idle, unenforced
      thr_w_q   <= thr_w_d;
      thr_h_q   <= thr_h_d;
      frac_en_q <= frac_en_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_TERMINAL_MARKER: terminal_marker_q <= cfg_data_i[IdW-1:0];
          REG_MIN_WIDTH:       min_width_q       <= cfg_data_i[PixW-1:0];
          REG_MIN_HEIGHT:      min_height_q      <= cfg_data_i[PixW-1:0];
          REG_MIN_FRACTION:    min_fraction_q    <= cfg_data_i[FracW-1:0];
          REG_IMAGE_WIDTH:     image_width_q     <= cfg_data_i[PixW-1:0];
          REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data_i[PixW-1:0];
          REG_MIN_FRAMES:      min_frames_q      <= cfg_data_i[CountW-1:0];
          REG_HOLD_TIME:       hold_time_q       <= cfg_data_i[HoldW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg_o.terminal_marker = terminal_marker_q;
    cfg_o.min_width       = min_width_q;
    cfg_o.min_height      = min_height_q;
    cfg_o.min_frames      = min_frames_q;
    cfg_o.hold_time       = hold_time_q;
    cfg_o.frac_en         = frac_en_q;
    cfg_o.thr_w           = thr_w_q;
    cfg_o.thr_h           = thr_h_q;
  end

endmodule

>>> rtl/core/mhps_core.sv
`timescale 1ns / 1ps
// Decision core: size test, run counter, hold timer and phase register.
// Depends on mhps_pkg.
module mhps_core #(
  parameter logic START_PHASE = 1'b0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  mhps_pkg::item_t item_i,
  input  mhps_pkg::cfg_t  cfg_i,
  output mhps_pkg::res_t  res_o
);
  import mhps_pkg::*;

  logic              phase_q, phase_d;
  logic [CountW-1:0] run_count_q, run_count_d;
  logic [TimeW-1:0]  start_q, start_d;

  logic              abs_ok, frac_ok, hit, sw;
  logic [ThrW-1:0]   bw_scaled, bh_scaled;
  logic [CountW-1:0] cnt_inc;
  logic [TimeW-1:0]  run_start, held;

  always_comb begin
    bw_scaled = ThrW'({item_i.box_width, FracSh'(0)});
    bh_scaled = ThrW'({item_i.box_height, FracSh'(0)});
    abs_ok  = (item_i.box_width >= cfg_i.min_width) && (item_i.box_height >= cfg_i.min_height);
    frac_ok = cfg_i.frac_en && ((bw_scaled >= cfg_i.thr_w) || (bh_scaled >= cfg_i.thr_h));
    hit     = !phase_q && (item_i.marker_id == cfg_i.terminal_marker) && (abs_ok || frac_ok);

    // saturate the run count at the limit
    cnt_inc   = (run_count_q < RunLimit) ? run_count_q + CountW'(1) : run_count_q;
    run_start = (run_count_q == '0) ? item_i.time_ms : start_q;
    held      = item_i.time_ms - run_start;
    sw        = hit && (cnt_inc >= cfg_i.min_frames) && (held >= TimeW'(cfg_i.hold_time));

    phase_d     = phase_q;
    run_count_d = run_count_q;
    start_d     = start_q;
    if (!phase_q) begin
      if (hit) begin
        start_d = run_start;
        if (sw) begin
          phase_d     = 1'b1;
          run_count_d = '0;
        end else begin
          run_count_d = cnt_inc;
        end
      end else begin
        run_count_d = '0;
      end
    end

    res_o.phase     = phase_d;
    res_o.switched  = sw;
    res_o.big_count = run_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= START_PHASE;
      run_count_q <= '0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      run_count_q <= run_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      start_q <= start_d;
    end
  end

  a_phase_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |=> phase_q) else $error("terminal phase left");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_count_q <= RunLimit) else $error("run count above limit");

  a_switch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.switched) |=> (phase_q && run_count_q == '0))
    else $error("switch did not set phase and clear count");

  a_terminal_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!res_o.switched && run_count_q == '0))
    else $error("activity in terminal phase");

endmodule

>>> rtl/core/marker_hold_phase_switch.sv
`timescale 1ns / 1ps
// Marker hold phase switch, top level. Depends on mhps_pkg, mhps_cfg, mhps_core.
//
// One result beat per detection beat, one beat per clock while the output is not
// stalled by m_axis_tready. A beat is captured in an input register, decided
// against the run counter and phase register, and its result is captured in
// the output register once the output register is free. Configuration writes
// reach the fraction thresholds through a further register (they are
// registered products); the user must make them while no beat is in flight,
// and the block does not enforce this.
module marker_hold_phase_switch #(
  parameter logic START_PHASE = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mhps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mhps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // marker_id[9:0], box_width[21:10], box_height[33:22], time_ms[65:34], zero pad
  input  logic [71:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // phase[0], switched[1], big_count[21:2], zero pad
  output logic [23:0]                   m_axis_tdata
);
  import mhps_pkg::*;

  cfg_t  cfg;
  item_t item_q, item_d;
  res_t  res, res_q;
  logic  in_vld_q, out_vld_q, advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    item_d.marker_id  = s_axis_tdata[9:0];
    item_d.box_width  = s_axis_tdata[21:10];
    item_d.box_height = s_axis_tdata[33:22];
    item_d.time_ms    = s_axis_tdata[65:34];
  end

  mhps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mhps_core #(
    .START_PHASE (START_PHASE)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q.big_count, res_q.switched, res_q.phase};

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for marker_hold_phase_switch: directed and random detection streams,
// each result beat checked against a behavioral model of the phase switch.
// Depends on mhps_pkg and the RTL under rtl/core.
module tb_top;
  import mhps_pkg::*;

  localparam logic        StartPhase = 1'b0;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PixMax     = 4095;

  typedef struct {
    logic [IdW-1:0]    marker;
    logic [PixW-1:0]   min_w;
    logic [PixW-1:0]   min_h;
    logic [FracW-1:0]  min_frac;
    logic [PixW-1:0]   img_w;
    logic [PixW-1:0]   img_h;
    logic [CountW-1:0] min_frames;
    logic [HoldW-1:0]  hold;
  } gate_cfg_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                det_tvalid;
  logic                det_tready;
  logic [71:0]         det_tdata;
  logic                ph_tvalid;
  logic                ph_tready;
  logic [23:0]         ph_tdata;

  // Model of the block: registers as written, phase and run state
  gate_cfg_t         gate;
  logic              phase_now;
  logic [CountW-1:0] run_len;
  logic [TimeW-1:0]  run_t0;

  res_t        phase_verdicts[$];
  int unsigned mismatch_count;
  logic [31:0] clock_ms;
  logic        feed_steady;
  logic        sink_steady;

  marker_hold_phase_switch #(
    .START_PHASE(StartPhase)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(det_tvalid),
    .s_axis_tready(det_tready),
    .s_axis_tdata (det_tdata),
    .m_axis_tvalid(ph_tvalid),
    .m_axis_tready(ph_tready),
    .m_axis_tdata (ph_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic gate_cfg_t make_cfg(input logic [IdW-1:0] marker,
                                         input logic [PixW-1:0] min_w,
                                         input logic [PixW-1:0] min_h,
                                         input logic [FracW-1:0] min_frac,
                                         input logic [PixW-1:0] img_w,
                                         input logic [PixW-1:0] img_h,
                                         input logic [CountW-1:0] min_frames,
                                         input logic [HoldW-1:0] hold);
    gate_cfg_t c;
    c.marker     = marker;
    c.min_w      = min_w;
    c.min_h      = min_h;
    c.min_frac   = min_frac;
    c.img_w      = img_w;
    c.img_h      = img_h;
    c.min_frames = min_frames;
    c.hold       = hold;
    return c;
  endfunction

  // Size gates drawn at random; each fraction input is zero a quarter of the time
  function automatic gate_cfg_t random_gate();
    gate_cfg_t c;
    c.marker     = IdW'($urandom);
    c.min_w      = PixW'($urandom_range(0, PixMax));
    c.min_h      = PixW'($urandom_range(0, PixMax));
    c.min_frac   = FracW'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 65536));
    c.img_w      = PixW'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, PixMax));
    c.img_h      = PixW'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, PixMax));
    c.min_frames = RunLimit;
    c.hold       = HoldW'($urandom);
    return c;
  endfunction

  function automatic logic box_is_big(input logic [PixW-1:0] bw, input logic [PixW-1:0] bh);
    longint unsigned need_w;
    longint unsigned need_h;
    logic            frac_ok;
    frac_ok = 1'b0;
    if (gate.min_frac != '0 && gate.img_w != '0 && gate.img_h != '0) begin
      need_w  = 64'(gate.min_frac) * 64'(gate.img_w);
      need_h  = 64'(gate.min_frac) * 64'(gate.img_h);
      frac_ok = (64'({bw, 16'h0}) >= need_w) || (64'({bh, 16'h0}) >= need_h);
    end
    return (bw >= gate.min_w && bh >= gate.min_h) || frac_ok;
  endfunction

  function automatic res_t predict_phase(input item_t d);
    res_t             r;
    logic [TimeW-1:0] held;
    r.switched = 1'b0;
    if (!phase_now) begin
      if (d.marker_id == gate.marker && box_is_big(d.box_width, d.box_height)) begin
        if (run_len == '0) run_t0 = d.time_ms;
        if (run_len < RunLimit) run_len = run_len + 1'b1;
        held = d.time_ms - run_t0;
        if (run_len >= gate.min_frames && held >= TimeW'(gate.hold)) begin
          phase_now  = 1'b1;
          r.switched = 1'b1;
          run_len    = '0;
        end
      end else begin
        run_len = '0;
      end
    end
    r.phase     = phase_now;
    r.big_count = run_len;
    return r;
  endfunction

  task automatic detect(input logic [IdW-1:0] id, input logic [PixW-1:0] bw,
                        input logic [PixW-1:0] bh, input logic [TimeW-1:0] t);
    item_t d;
    int    gap;
    d.marker_id  = id;
    d.box_width  = bw;
    d.box_height = bh;
    d.time_ms    = t;
    gap = feed_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      det_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    det_tvalid <= 1'b1;
    det_tdata  <= {6'b0, d.time_ms, d.box_height, d.box_width, d.marker_id};
    do @(posedge clk_i); while (!det_tready);
    phase_verdicts.push_back(predict_phase(d));
  endtask

  task automatic drain_results();
    det_tvalid <= 1'b0;
    while (phase_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic load_config(input gate_cfg_t c);
    drain_results();
    write_reg(REG_TERMINAL_MARKER, CfgDataW'(c.marker));
    write_reg(REG_MIN_WIDTH, CfgDataW'(c.min_w));
    write_reg(REG_MIN_HEIGHT, CfgDataW'(c.min_h));
    write_reg(REG_MIN_FRACTION, CfgDataW'(c.min_frac));
    write_reg(REG_IMAGE_WIDTH, CfgDataW'(c.img_w));
    write_reg(REG_IMAGE_HEIGHT, CfgDataW'(c.img_h));
    write_reg(REG_MIN_FRAMES, CfgDataW'(c.min_frames));
    write_reg(REG_HOLD_TIME, CfgDataW'(c.hold));
    cfg_we <= 1'b0;
    // thresholds are registered products, let them settle
    repeat (2) @(posedge clk_i);
    gate = c;
  endtask

  // Mostly well-formed runs of big terminal-marker detections, broken by noise
  task automatic random_runs(input int n, input int delta_max);
    logic [IdW-1:0]  id;
    logic [PixW-1:0] bw;
    logic [PixW-1:0] bh;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        feed_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 7) != 0) begin
        id = gate.marker;
        case ($urandom_range(0, 3))
          0: begin
            bw = PixW'(gate.min_w - 1 + $urandom_range(0, 2));
            bh = PixW'(gate.min_h - 1 + $urandom_range(0, 2));
          end
          1: begin
            bw = PixW'($urandom_range(0, PixMax));
            bh = PixW'($urandom_range(0, PixMax));
          end
          default: begin
            bw = PixW'($urandom_range(gate.min_w, PixMax));
            bh = PixW'($urandom_range(gate.min_h, PixMax));
          end
        endcase
      end else begin
        id = IdW'($urandom);
        bw = PixW'($urandom_range(0, PixMax));
        bh = PixW'($urandom_range(0, PixMax));
      end
      clock_ms = clock_ms + $urandom_range(0, delta_max);
      detect(id, bw, bh, clock_ms);
    end
    feed_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_size_gate();
    load_config(make_cfg(5, 100, 50, 0, 640, 480, RunLimit, 16'hFFFF));
    detect(5, 100, 50, 32'd1000);
    detect(5, 99, 50, 32'd1001);
    detect(5, 100, 49, 32'd1002);
    detect(5, 4095, 4095, 32'd1003);
    detect(5, 4095, 4095, 32'd1004);
    detect(4, 4095, 4095, 32'd1005);
    detect(1023, 0, 0, 32'd1006);
  endtask

  task automatic test_fraction_gate();
    // half the image: 320 of 640 wide or 240 of 480 high passes
    load_config(make_cfg(1023, 4095, 4095, 32768, 640, 480, RunLimit, 16'hFFFF));
    detect(1023, 320, 0, 32'h8000_0000);
    detect(1023, 319, 239, 32'h8000_0001);
    detect(1023, 0, 240, 32'h8000_0002);
    detect(1023, 4095, 4095, 32'h8000_0003);
    // a zero image dimension turns the fraction test off
    load_config(make_cfg(1023, 4095, 4095, 32768, 0, 480, RunLimit, 16'hFFFF));
    detect(1023, 320, 240, 32'h8000_0004);
    load_config(make_cfg(1023, 4095, 4095, 32768, 640, 0, RunLimit, 16'hFFFF));
    detect(1023, 640, 0, 32'h8000_0005);
    // full image fraction is met only by a box as large as the image
    load_config(make_cfg(1023, 4095, 4095, 65536, 4095, 4095, RunLimit, 16'hFFFF));
    detect(1023, 4095, 0, 32'h8000_0006);
    detect(1023, 4094, 4094, 32'h8000_0007);
  endtask

  task automatic test_hold_wrap();
    load_config(make_cfg(0, 0, 0, 0, 0, 0, 1, 16));
    detect(0, 0, 0, 32'hFFFF_FFF8);
    detect(0, 1, 1, 32'h0000_0006);
    detect(0, 2, 2, 32'h0000_0007);
    detect(1, 4095, 4095, 32'h0000_0008);
    // new run restarts its clock
    detect(0, 4095, 4095, 32'h0000_1000);
    detect(0, 4095, 4095, 32'h0000_100F);
  endtask

  task automatic test_random_short_frames();
    gate_cfg_t c;
    c            = random_gate();
    c.min_frames = CountW'($urandom_range(1, 8));
    c.hold       = HoldW'($urandom_range(2000, 65535));
    load_config(c);
    clock_ms = $urandom;
    random_runs(125, 20);
    // hold off until every result is back, then resume mid-run
    drain_results();
    random_runs(125, 20);
  endtask

  task automatic test_random_short_hold();
    gate_cfg_t c;
    c            = random_gate();
    c.min_frames = CountW'($urandom_range(300, RunLimit));
    c.hold       = HoldW'($urandom_range(0, 200));
    load_config(c);
    clock_ms = $urandom;
    random_runs(125, 50);
    c            = random_gate();
    c.min_frames = RunLimit;
    c.hold       = '0;
    load_config(c);
    random_runs(125, 50);
  endtask

  task automatic test_random_gates();
    load_config(make_cfg(1023, 4095, 4095, 65536, 4095, 4095, RunLimit, 16'hFFFF));
    clock_ms = $urandom;
    random_runs(45, 1000);
    load_config(make_cfg(0, 0, 0, 0, 0, 0, RunLimit, 0));
    random_runs(45, 1000);
    for (int k = 0; k < 4; k++) begin
      load_config(random_gate());
      random_runs(45, 1000);
    end
  endtask

  task automatic test_frozen_clock();
    logic [IdW-1:0] id;
    id = IdW'($urandom);
    load_config(make_cfg(id, 0, 0, 0, 0, 0, RunLimit, 16'hFFFF));
    feed_steady = 1'b1;
    sink_steady = 1'b1;
    clock_ms    = $urandom;
    // frozen clock keeps the hold short of its minimum, so the count only climbs
    for (int k = 0; k < 20; k++) begin
      detect(id, PixW'($urandom), PixW'($urandom), clock_ms);
    end
    detect(id + 1'b1, 4095, 4095, clock_ms);
    feed_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_terminal_switch();
    load_config(make_cfg(7, 10, 10, 0, 640, 480, 3, 10));
    detect(7, 10, 10, 32'hFFFF_FFFE);
    detect(7, 20, 30, 32'h0000_0003);
    detect(7, 4095, 10, 32'h0000_0008);
    // terminal from here on: nothing moves the phase or the count
    clock_ms = 32'h0000_0010;
    random_runs(15, 5);
    load_config(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
    random_runs(15, 5);
  endtask

  task automatic flag_mismatch(input string why, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%s: exp phase=%0d sw=%0d count=%0d, got phase=%0d sw=%0d count=%0d",
               why, want.phase, want.switched, want.big_count,
               got.phase, got.switched, got.big_count);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni && ph_tvalid && ph_tready) begin
      got = res_t'(ph_tdata[21:0]);
      if (phase_verdicts.size() == 0) begin
        want = '0;
        flag_mismatch("unexpected beat", want, got);
      end else begin
        want = phase_verdicts.pop_front();
        if (got.phase !== want.phase || got.switched !== want.switched ||
            got.big_count !== want.big_count) begin
          flag_mismatch("mismatch", want, got);
        end
      end
    end
  end

  initial begin : sink_side
    int stall;
    ph_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        ph_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ph_tready <= 1'b1;
      do @(posedge clk_i); while (!ph_tvalid);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_TERMINAL_MARKER;
    cfg_data       <= '0;
    det_tvalid     <= 1'b0;
    det_tdata      <= '0;
    gate           = make_cfg(0, 0, 0, 0, 0, 0, 0, 0);
    phase_now      = StartPhase;
    run_len        = '0;
    run_t0         = '0;
    mismatch_count = 0;
    clock_ms       = '0;
    feed_steady    = 1'b0;
    sink_steady    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_size_gate();
    test_fraction_gate();
    test_hold_wrap();
    test_random_short_frames();
    test_random_short_hold();
    test_random_gates();
    test_frozen_clock();
    test_terminal_switch();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && phase_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mhps_pkg.sv
rtl/core/mhps_cfg.sv
rtl/core/mhps_core.sv
rtl/core/marker_hold_phase_switch.sv
dv/tb_top.sv
